// ===== rtl/lib_pkg.sv =====
//------------------------------------------------------------------------------
// lib_pkg: shared types and constants of the line intersection block
// Holds the reason codes, the quotient width and the box register indices.
//------------------------------------------------------------------------------
package lib_pkg;

  typedef enum logic [1:0] {
    RSN_OK       = 2'd0,
    RSN_PARALLEL = 2'd1,
    RSN_RANGE    = 2'd2,
    RSN_OUTSIDE  = 2'd3
  } reason_e;

  localparam int unsigned QBITS = 32;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_e;

endpackage

// ===== rtl/lib_div_cell.sv =====
//------------------------------------------------------------------------------
// lib_div_cell: one stage of the restoring divider chain
// Takes one dividend bit, updates remainder and saturating quotient, and
// hands the result to the next cell every cycle in which en_i is high.
//------------------------------------------------------------------------------
module lib_div_cell
  import lib_pkg::*;
#(
  parameter int unsigned NBITS = 64,
  parameter int unsigned DBITS = 32,
  parameter int unsigned BIT   = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NBITS-1:0] num_i,
  input  logic [DBITS-1:0] den_i,
  input  logic [DBITS:0]   rem_i,
  input  logic [QBITS-1:0] quo_i,
  input  logic             ovf_i,
  output logic [NBITS-1:0] num_o,
  output logic [DBITS-1:0] den_o,
  output logic [DBITS:0]   rem_o,
  output logic [QBITS-1:0] quo_o,
  output logic             ovf_o
);

  logic [DBITS+1:0] sh;
  logic             ge;
  logic [DBITS:0]   rem_d;
  logic [QBITS:0]   q_sh;
  logic [QBITS-1:0] quo_d;
  logic             ovf_d;

  // shift in one bit, compare, subtract
  always_comb begin
    sh    = {rem_i, num_i[BIT]};
    ge    = sh >= {2'b00, den_i};
    rem_d = ge ? (DBITS+1)'(sh - {2'b00, den_i}) : sh[DBITS:0];
    q_sh  = {quo_i, ge};
    ovf_d = ovf_i;
    quo_d = q_sh[QBITS-1:0];
    if (q_sh[QBITS:QBITS-1] != 2'b00) begin
      ovf_d = 1'b1;
      quo_d = {1'b1, {(QBITS-1){1'b0}}};
    end
  end

  // advance one cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i;
      den_o <= den_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
      ovf_o <= ovf_d;
    end
  end

endmodule

// ===== rtl/line_intersection_bbox.sv =====
//------------------------------------------------------------------------------
// line_intersection_bbox: intersection of two segment lines with box check
// Cramer's rule with exact products and a chain of divider cells per axis.
//------------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; the divider is a chain
// of one cell per numerator bit, so each item advances one cell per cycle.
// The whole pipe stalls together when the output register is full and not taken.
// Reset clears valid bits and loads the default box; data needs no reset.
module line_intersection_bbox
  import lib_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // in_start_x, in_start_y, in_end_x, in_end_y, out_start_x, out_start_y,
  // out_end_x, out_end_y
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found, reason, point_x, point_y, zero pad
  output logic [((3+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DB = 2*C+2;        // |det| bits
  localparam int unsigned NB = 4*C+2;        // |num|+half bits
  localparam int unsigned ST = 4;            // front stages
  localparam int unsigned OW = ((3+2*C+7)/8)*8;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // box registers
  logic signed [C-1:0] left_q, bottom_q, right_q, top_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      bottom_q <= '0;
      right_q  <= {1'b0, {(C-1){1'b1}}};
      top_q    <= {1'b0, {(C-1){1'b1}}};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // stage 1: line coefficients
  logic signed [C-1:0] xi0, yi0, xi1, yi1, xo0, yo0, xo1, yo1;
  assign xi0 = s_axis_tdata[0*C +: C];
  assign yi0 = s_axis_tdata[1*C +: C];
  assign xi1 = s_axis_tdata[2*C +: C];
  assign yi1 = s_axis_tdata[3*C +: C];
  assign xo0 = s_axis_tdata[4*C +: C];
  assign yo0 = s_axis_tdata[5*C +: C];
  assign xo1 = s_axis_tdata[6*C +: C];
  assign yo1 = s_axis_tdata[7*C +: C];

  logic [ST-1:0] vld_q;
  logic signed [C:0]     a0_q, b0_q, a1_q, b1_q;
  logic signed [2*C:0]   c0_q, c1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a0_q <= (C+1)'(yi1) - (C+1)'(yi0);
      b0_q <= (C+1)'(xi0) - (C+1)'(xi1);
      a1_q <= (C+1)'(yo1) - (C+1)'(yo0);
      b1_q <= (C+1)'(xo0) - (C+1)'(xo1);
      c0_q <= (2*C+1)'(xi0 * yi1) - (2*C+1)'(yi0 * xi1);
      c1_q <= (2*C+1)'(xo0 * yo1) - (2*C+1)'(yo0 * xo1);
    end
  end

  // stage 2: products
  logic signed [2*C+1:0] p_ab0_q, p_ab1_q;
  logic signed [3*C+1:0] px0_q, px1_q, py0_q, py1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_ab0_q <= (2*C+2)'(a0_q * b1_q);
      p_ab1_q <= (2*C+2)'(a1_q * b0_q);
      px0_q   <= (3*C+2)'(c0_q * b1_q);
      px1_q   <= (3*C+2)'(c1_q * b0_q);
      py0_q   <= (3*C+2)'(a0_q * c1_q);
      py1_q   <= (3*C+2)'(a1_q * c0_q);
    end
  end

  // stage 3: determinant and numerators
  logic signed [2*C+2:0] det_q;
  logic signed [3*C+2:0] xn_q, yn_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q <= (2*C+3)'(p_ab0_q) - (2*C+3)'(p_ab1_q);
      xn_q  <= (3*C+3)'(px0_q) - (3*C+3)'(px1_q);
      yn_q  <= (3*C+3)'(py0_q) - (3*C+3)'(py1_q);
    end
  end

  // stage 4: magnitudes, rounding offset, signs
  logic [DB-1:0] dmag;
  logic [3*C+2:0] xm, ym;
  assign dmag = det_q[2*C+2] ? DB'(-det_q) : DB'(det_q);
  assign xm   = xn_q[3*C+2] ? (3*C+3)'(-xn_q) : (3*C+3)'(xn_q);
  assign ym   = yn_q[3*C+2] ? (3*C+3)'(-yn_q) : (3*C+3)'(yn_q);

  logic [NB-1:0] xnum_q, ynum_q;
  logic [DB-1:0] den_q;
  logic          par_q, xneg_q, yneg_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xnum_q <= NB'(xm) + NB'(dmag >> 1);
      ynum_q <= NB'(ym) + NB'(dmag >> 1);
      den_q  <= dmag;
      par_q  <= det_q == '0;
      xneg_q <= xn_q[3*C+2] ^ det_q[2*C+2];
      yneg_q <= yn_q[3*C+2] ^ det_q[2*C+2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[ST-2:0], s_axis_tvalid};
  end

  // divider chains, one cell per numerator bit, MSB first
  logic [NB-1:0]    xn_c [0:NB], yn_c [0:NB];
  logic [DB-1:0]    xd_c [0:NB], yd_c [0:NB];
  logic [DB:0]      xr_c [0:NB], yr_c [0:NB];
  logic [QBITS-1:0] xq_c [0:NB], yq_c [0:NB];
  logic             xo_c [0:NB], yo_c [0:NB];
  logic             v_c [0:NB], par_c [0:NB], xs_c [0:NB], ys_c [0:NB];

  assign xn_c[0] = xnum_q;  assign yn_c[0] = ynum_q;
  assign xd_c[0] = den_q;   assign yd_c[0] = den_q;
  assign xr_c[0] = '0;      assign yr_c[0] = '0;
  assign xq_c[0] = '0;      assign yq_c[0] = '0;
  assign xo_c[0] = 1'b0;    assign yo_c[0] = 1'b0;
  assign v_c[0]  = vld_q[ST-1];
  assign par_c[0] = par_q;
  assign xs_c[0] = xneg_q;
  assign ys_c[0] = yneg_q;

  for (genvar g = 0; g < NB; g++) begin : g_cell
    lib_div_cell #(.NBITS(NB), .DBITS(DB), .BIT(NB-1-g)) u_x (
      .clk_i, .en_i(adv),
      .num_i(xn_c[g]), .den_i(xd_c[g]), .rem_i(xr_c[g]), .quo_i(xq_c[g]),
      .ovf_i(xo_c[g]),
      .num_o(xn_c[g+1]), .den_o(xd_c[g+1]), .rem_o(xr_c[g+1]),
      .quo_o(xq_c[g+1]), .ovf_o(xo_c[g+1])
    );
    lib_div_cell #(.NBITS(NB), .DBITS(DB), .BIT(NB-1-g)) u_y (
      .clk_i, .en_i(adv),
      .num_i(yn_c[g]), .den_i(yd_c[g]), .rem_i(yr_c[g]), .quo_i(yq_c[g]),
      .ovf_i(yo_c[g]),
      .num_o(yn_c[g+1]), .den_o(yd_c[g+1]), .rem_o(yr_c[g+1]),
      .quo_o(yq_c[g+1]), .ovf_o(yo_c[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        par_c[g+1] <= par_c[g];
        xs_c[g+1]  <= xs_c[g];
        ys_c[g+1]  <= ys_c[g];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_c[g+1] <= 1'b0;
      else if (adv) v_c[g+1] <= v_c[g];
    end
  end

  // final check and output register
  logic [QBITS-1:0] qx, qy;
  logic bad, outside;
  reason_e rsn;
  assign qx = xq_c[NB];
  assign qy = yq_c[NB];
  always_comb begin
    bad = xo_c[NB] || yo_c[NB] || (xs_c[NB] && qx != '0) || (ys_c[NB] && qy != '0);
    outside = ($signed({1'b0, qx}) < $signed({{(QBITS+1-C){left_q[C-1]}}, left_q}))
           || ($signed({1'b0, qx}) > $signed({{(QBITS+1-C){right_q[C-1]}}, right_q}))
           || ($signed({1'b0, qy}) < $signed({{(QBITS+1-C){bottom_q[C-1]}}, bottom_q}))
           || ($signed({1'b0, qy}) > $signed({{(QBITS+1-C){top_q[C-1]}}, top_q}));
    if (par_c[NB])    rsn = RSN_PARALLEL;
    else if (bad)     rsn = RSN_RANGE;
    else if (outside) rsn = RSN_OUTSIDE;
    else              rsn = RSN_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v_c[NB];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= OW'({ (rsn == RSN_OK) ? qy[C-1:0] : {C{1'b0}},
                            (rsn == RSN_OK) ? qx[C-1:0] : {C{1'b0}},
                            rsn, rsn == RSN_OK });
    end
  end

`ifndef SYNTHESIS
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == RSN_OK)))
    else $error("found flag disagrees with reason");
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3+:2*C] == '0))
    else $error("rejected point not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
`endif

endmodule
